[hw/rtl/tvc_pkg.sv]
// ----------------------------------------------------------------------------
// tvc_pkg
// Shared types, constants and the quarter-wave sine table of the two-voice
// chorus: sequencer states, control bundles and configuration register codes.
// ----------------------------------------------------------------------------
package tvc_pkg;

  // Voice count; voices are averaged by an arithmetic shift, so it is a
  // power of two.
  localparam int TVC_VOICES      = 2;
  localparam int TVC_VOICE_SHIFT = $clog2(TVC_VOICES);
  localparam int TVC_VIDX_W      = (TVC_VOICES > 1) ? $clog2(TVC_VOICES) : 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int STEP_W  = 16;
  localparam int BASE_W  = 10;
  localparam int SPAN_W  = 10;
  localparam int DEPTH_W = 9;
  localparam int MIX_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_SPAN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX    = 3'd4;

  localparam logic [STEP_W-1:0]  RST_LFO_STEP   = 16'd350;
  localparam logic [BASE_W-1:0]  RST_BASE_DELAY = 10'd336;
  localparam logic [SPAN_W-1:0]  RST_MOD_SPAN   = 10'd96;
  localparam logic [DEPTH_W-1:0] RST_MOD_DEPTH  = 9'd128;
  localparam logic [MIX_W-1:0]   RST_WET_MIX    = 9'd128;

  // Unsigned coefficient operand of the shared multiplier.
  localparam int COEF_W = 10;

  // Q8 unity.
  localparam logic [8:0] Q8_ONE = 9'd256;

  // Sine in Q1.15 with a sign bit of its own.
  localparam int SINE_W = 17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LFO,
    ST_MSPAN,
    ST_MDEPTH,
    ST_DELAY,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_TAP1,
    ST_SUM,
    ST_WET,
    ST_MIXW,
    ST_OUT
  } tvc_state_t;

  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic advance;
  } dl_ctrl_t;

  localparam logic [15:0] QUARTER_SINE [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
    16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
    16'd18204, 16'd18867, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
    16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
    16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
    16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
    16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
    16'd32767
  };

  // The top two bits of the phase pick the quadrant; odd quadrants run the
  // table backwards and the upper half of the cycle is negated.
  function automatic logic signed [SINE_W-1:0] lfo_sine(input logic [7:0] top);
    logic [1:0]               quad;
    logic [5:0]               idx;
    logic [6:0]               k;
    logic signed [SINE_W-1:0] mag;
    quad = top[7:6];
    idx  = top[5:0];
    k    = quad[0] ? (7'd64 - {1'b0, idx}) : {1'b0, idx};
    mag  = $signed({1'b0, QUARTER_SINE[k]});
    return quad[1] ? -mag : mag;
  endfunction

endpackage

[hw/rtl/tvc_mac.sv]
// ----------------------------------------------------------------------------
// tvc_mac
// Shared multiply-accumulate unit: signed operand times unsigned coefficient,
// either loaded into or added onto a registered accumulator.
// ----------------------------------------------------------------------------
module tvc_mac #(
  parameter int A_W   = 26,
  parameter int ACC_W = 38
) (
  input  logic                          clk,
  input  tvc_pkg::mac_ctrl_t            ctrl,
  input  logic signed [A_W-1:0]         a,
  input  logic [tvc_pkg::COEF_W-1:0]    b,
  output logic signed [ACC_W-1:0]       acc
);
  import tvc_pkg::*;

  logic signed [A_W+COEF_W:0] prod;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;

  assign prod    = a * $signed({1'b0, b});
  assign acc_nxt = (ctrl.clear ? '0 : acc_r) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[hw/rtl/tvc_delay_line.sv]
// ----------------------------------------------------------------------------
// tvc_delay_line
// Circular sample store with one write and one registered read port. A wrap
// flag and the write pointer mark which entries hold samples; the rest read
// as zero, so the store needs no clearing after reset.
// ----------------------------------------------------------------------------
module tvc_delay_line #(
  parameter int BUF_DEPTH   = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tvc_pkg::dl_ctrl_t              ctrl,
  input  logic signed [SAMPLE_BITS-1:0]  wr_data,
  input  logic [$clog2(BUF_DEPTH)-1:0]   rd_addr,
  output logic [$clog2(BUF_DEPTH)-1:0]   wr_ptr,
  output logic signed [SAMPLE_BITS-1:0]  rd_data
);
  import tvc_pkg::*;

  localparam int AB = $clog2(BUF_DEPTH);

  logic [SAMPLE_BITS-1:0] line_mem [BUF_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rd_ok_r;
  logic [AB-1:0]          wp_r;
  logic                   wrapped_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      line_mem[wp_r] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // An entry holds a sample once the pointer has reached it, or after the
  // first wrap of the pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        rd_ok_r <= wrapped_r || (rd_addr <= wp_r);
      end
      if (ctrl.advance) begin
        if (wp_r == AB'(BUF_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
    end
  end

  assign wr_ptr  = wp_r;
  assign rd_data = rd_ok_r ? $signed(rd_data_r) : '0;

endmodule

[hw/rtl/two_voice_chorus_core.sv]
// Samples are processed one at a time (in_stall is high while the sequencer is busy); each voice
// takes nine sequencer steps through the one multiply-accumulate unit and the single delay line
// read port.
// Reset (synchronous, rst_n low): configuration registers to defaults, phases to i/VOICES of a cycle, write
// pointer to zero; delay line entries not yet written read as zero, with no clearing pass.
// ----------------------------------------------------------------------------
// two_voice_chorus_core
// Chorus effect: modulated fractional delay per voice, linear interpolation,
// voice average, Q8 wet/dry blend and saturation, run by a small sequencer.
// ----------------------------------------------------------------------------
module two_voice_chorus_core #(
  parameter int BUF_DEPTH   = 2048,
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_audio_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_audio_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tvc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tvc_pkg::*;

  localparam int AB    = $clog2(BUF_DEPTH);
  localparam int AW    = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
  localparam int ACC_W = AW + COEF_W + 2;
  localparam int QW    = (AB + 9 > 21) ? AB + 9 : 21;
  localparam int SW    = SAMPLE_BITS + TVC_VOICE_SHIFT;

  localparam logic signed [QW-1:0]    D_MIN  = QW'(256);
  localparam logic signed [QW-1:0]    D_MAX  = QW'((BUF_DEPTH - 2) * 256);
  localparam logic signed [QW-1:0]    RING   = QW'(BUF_DEPTH * 256);
  localparam logic signed [ACC_W-1:0] Y_MAX  =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN  = ~Y_MAX;

  // Configuration registers.
  logic [STEP_W-1:0]  step_r;
  logic [BASE_W-1:0]  base_r;
  logic [SPAN_W-1:0]  span_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [MIX_W-1:0]   mix_r;
  logic [DEPTH_W-1:0] depth_eff;
  logic [MIX_W-1:0]   mix_eff;

  tvc_state_t state_r;
  tvc_state_t state_nxt;

  logic [TVC_VIDX_W-1:0]         vidx_r;
  logic                          last_voice;
  logic [PHASE_BITS-1:0]         phase_r [TVC_VOICES];
  logic [PHASE_BITS-1:0]         cur_phase;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SINE_W-1:0]      s_r;
  logic [AB+7:0]                 d_r;
  logic [AB-1:0]                 i0_r;
  logic [AB-1:0]                 i1_r;
  logic [7:0]                    f_r;
  logic signed [SW-1:0]          sum_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                          out_valid_r;

  logic signed [QW-1:0]          d_sum;
  logic signed [QW-1:0]          d_clamped;
  logic signed [QW-1:0]          r_full;
  logic signed [QW-1:0]          r_wrap;
  logic signed [SAMPLE_BITS-1:0] tap_val;
  logic signed [SAMPLE_BITS-1:0] wet;
  logic signed [ACC_W-1:0]       y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          out_free;

  mac_ctrl_t                     mac_ctrl;
  logic signed [AW-1:0]          mac_a;
  logic [COEF_W-1:0]             mac_b;
  logic signed [ACC_W-1:0]       mac_acc;

  dl_ctrl_t                      dl_ctrl;
  logic [AB-1:0]                 rd_addr;
  logic [AB-1:0]                 wp;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  tvc_mac #(
    .A_W   (AW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc)
  );

  tvc_delay_line #(
    .BUF_DEPTH   (BUF_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_delay_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (dl_ctrl),
    .wr_data (in_audio_in),
    .rd_addr (rd_addr),
    .wr_ptr  (wp),
    .rd_data (rd_data)
  );

  assign depth_eff = (depth_r > DEPTH_W'(Q8_ONE)) ? DEPTH_W'(Q8_ONE) : depth_r;
  assign mix_eff   = (mix_r > MIX_W'(Q8_ONE)) ? MIX_W'(Q8_ONE) : mix_r;

  assign last_voice = (vidx_r == TVC_VIDX_W'(TVC_VOICES - 1));
  assign cur_phase  = phase_r[vidx_r];

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Delay in Q8 samples: centre plus the scaled sine, floored, then clamped.
  assign d_sum     = $signed(QW'({base_r, 8'd0})) + QW'(mac_acc >>> 15);
  assign d_clamped = (d_sum < D_MIN) ? D_MIN : ((d_sum > D_MAX) ? D_MAX : d_sum);

  // Read position behind the write pointer, wrapped around the ring.
  assign r_full = $signed(QW'({wp, 8'd0})) - $signed(QW'(d_r));
  assign r_wrap = (r_full < 0) ? (r_full + RING) : r_full;

  assign tap_val = SAMPLE_BITS'(mac_acc >>> 8);
  assign wet     = SAMPLE_BITS'(sum_r >>> TVC_VOICE_SHIFT);
  assign y_full  = mac_acc >>> 8;
  assign y_sat   = (y_full > Y_MAX) ? SAMPLE_BITS'(Y_MAX) :
                   ((y_full < Y_MIN) ? SAMPLE_BITS'(Y_MIN) : SAMPLE_BITS'(y_full));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mac_ctrl  = '0;
    mac_a     = '0;
    mac_b     = '0;
    dl_ctrl   = '0;
    rd_addr   = i0_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dl_ctrl.wr_en = 1'b1;
          state_nxt     = ST_LFO;
        end
      end
      ST_LFO: begin
        state_nxt = ST_MSPAN;
      end
      ST_MSPAN: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b1};
        mac_a     = AW'(s_r);
        mac_b     = COEF_W'(span_r);
        state_nxt = ST_MDEPTH;
      end
      ST_MDEPTH: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b1};
        mac_a     = $signed(mac_acc[AW-1:0]);
        mac_b     = COEF_W'(depth_eff);
        state_nxt = ST_DELAY;
      end
      ST_DELAY: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_RD0;
      end
      ST_RD0: begin
        dl_ctrl.rd_en = 1'b1;
        rd_addr       = i0_r;
        state_nxt     = ST_RD1;
      end
      ST_RD1: begin
        dl_ctrl.rd_en = 1'b1;
        rd_addr       = i1_r;
        mac_ctrl      = '{en: 1'b1, clear: 1'b1};
        mac_a         = AW'(rd_data);
        mac_b         = COEF_W'(Q8_ONE) - COEF_W'(f_r);
        state_nxt     = ST_TAP1;
      end
      ST_TAP1: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b0};
        mac_a     = AW'(rd_data);
        mac_b     = COEF_W'(f_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = last_voice ? ST_WET : ST_LFO;
      end
      ST_WET: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b1};
        mac_a     = AW'(x_r);
        mac_b     = COEF_W'(Q8_ONE) - COEF_W'(mix_eff);
        state_nxt = ST_MIXW;
      end
      ST_MIXW: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b0};
        mac_a     = AW'(wet);
        mac_b     = COEF_W'(mix_eff);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          dl_ctrl.advance = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= RST_LFO_STEP;
      base_r  <= RST_BASE_DELAY;
      span_r  <= RST_MOD_SPAN;
      depth_r <= RST_MOD_DEPTH;
      mix_r   <= RST_WET_MIX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LFO_STEP:   step_r  <= cfg_data[STEP_W-1:0];
        CFG_BASE_DELAY: base_r  <= cfg_data[BASE_W-1:0];
        CFG_MOD_SPAN:   span_r  <= cfg_data[SPAN_W-1:0];
        CFG_MOD_DEPTH:  depth_r <= cfg_data[DEPTH_W-1:0];
        CFG_WET_MIX:    mix_r   <= cfg_data[MIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Voice index and LFO phases.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r <= '0;
      for (int i = 0; i < TVC_VOICES; i++) begin
        phase_r[i] <= PHASE_BITS'((64'(i) << PHASE_BITS) >> TVC_VOICE_SHIFT);
      end
    end else if (state_r == ST_IDLE) begin
      vidx_r <= '0;
    end else if (state_r == ST_SUM) begin
      phase_r[vidx_r] <= cur_phase + PHASE_BITS'(step_r);
      vidx_r          <= last_voice ? '0 : vidx_r + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      x_r   <= in_audio_in;
      sum_r <= '0;
    end
    if (state_r == ST_LFO) begin
      s_r <= lfo_sine(cur_phase[PHASE_BITS-1 -: 8]);
    end
    if (state_r == ST_DELAY) begin
      d_r <= (AB+8)'(d_clamped);
    end
    if (state_r == ST_ADDR) begin
      i0_r <= r_wrap[AB+7:8];
      f_r  <= r_wrap[7:0];
    end
    if (state_r == ST_RD0) begin
      i1_r <= (i0_r == AB'(BUF_DEPTH - 1)) ? '0 : i0_r + 1'b1;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_r + SW'(tap_val);
    end
  end

  // Output register; the next sample may be accepted while this one waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_r <= y_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_r;

endmodule
